// ----- rtl/core/msbf_pkg.sv -----
// Shared constants, types and codes of the multi-source Bellman-Ford block.
package msbf_pkg;

  localparam int unsigned MAX_VERTICES = 1024;
  localparam int unsigned MAX_EDGES    = 4096;
  localparam int unsigned LANES        = 64;

  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned EW = $clog2(MAX_EDGES);
  localparam int unsigned LW = $clog2(LANES);
  localparam int unsigned DAW = VW + LW;
  localparam int unsigned DIST_DEPTH = MAX_VERTICES * LANES;
  localparam int unsigned ES_DEPTH = MAX_VERTICES + 1;

  localparam logic signed [62:0] DIST_INF = {1'b0, {62{1'b1}}};
  localparam logic signed [62:0] DIST_MIN = {1'b1, {62{1'b0}}};

  typedef enum logic [2:0] {
    ACT_LOAD_OFS = 3'd0,
    ACT_LOAD_EDGE = 3'd1,
    ACT_CLEAR = 3'd2,
    ACT_SET_SRC = 3'd3,
    ACT_RELAX = 3'd4,
    ACT_QUERY = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    CFG_VCOUNT = 2'd0,
    CFG_LCOUNT = 2'd1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_V_RD0,
    ST_V_RD1,
    ST_V_CHK,
    ST_E_RD,
    ST_E_CHK,
    ST_L_SRC,
    ST_L_DST,
    ST_L_CMP,
    ST_PASS_END,
    ST_Q_WAIT,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic              upd;
    logic signed [62:0] sum;
  } relax_res_t;

endpackage

// ----- rtl/core/msbf_ram.sv -----
// Generic single-port RAM with registered read.
module msbf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// ----- rtl/core/msbf_relax_alu.sv -----
// Shared relax unit: saturating add of distance and weight, compare to target.
module msbf_relax_alu
  import msbf_pkg::*;
(
  input  logic signed [62:0] src_i,
  input  logic signed [31:0] weight_i,
  input  logic signed [62:0] dst_i,
  output relax_res_t         res_o
);

  logic signed [63:0] raw;
  logic signed [62:0] sat;

  always_comb begin
    raw = 64'(src_i) + 64'(weight_i);
    if (raw > 64'(DIST_INF)) begin
      sat = DIST_INF;
    end else if (raw < 64'(DIST_MIN)) begin
      sat = DIST_MIN;
    end else begin
      sat = raw[62:0];
    end
    res_o.sum = sat;
    // unreached source relaxes nothing
    res_o.upd = (src_i < DIST_INF) && (sat < dst_i);
  end

endmodule

// ----- rtl/core/multi_source_bellman_ford.sv -----
// Multi-source Bellman-Ford top level: sequencer, stores and handshakes.
//
// Load offset, load edge and set source are done in the idle state as they are
// accepted; a query reads the distance memory and waits until the output
// register is free. Clear distances (and reset) runs a clearing pass over all
// 65536 entries of the distance memory, one entry a cycle, during which no
// word is accepted; configuration writes are still taken. A relax steps through
// each vertex, each of its edges and each active lane in turn, through the
// single-port distance memory and the one shared relax unit, and repeats sweeps
// until one changes nothing or vertex_count sweeps ran.
module multi_source_bellman_ford
  import msbf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [10:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         action_i,
  input  logic [12:0]        slot_i,
  input  logic [12:0]        offset_value_i,
  input  logic [9:0]         vertex_i,
  input  logic signed [31:0] edge_weight_i,
  input  logic [5:0]         lane_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               result_kind_o,
  output logic signed [62:0] distance_o,
  output logic               reachable_o,
  output logic [10:0]        passes_o,
  output logic               converged_o
);

  state_e state_q, state_d;
  logic [10:0] vcount_q, lcount_q7;
  logic [6:0]  lcount_q;
  logic [10:0] nv;
  logic [6:0]  nl;

  logic [DAW-1:0] clr_q, clr_d;
  logic [10:0] v_q, v_d;
  logic [12:0] lo_q, lo_d, hi_q, hi_d, e_q, e_d;
  logic [VW-1:0] nb_q, nb_d;
  logic signed [31:0] w_q, w_d;
  logic [6:0] l_q, l_d;
  logic signed [62:0] src_q, src_d;
  logic changed_q, changed_d;
  logic [10:0] pass_q, pass_d;
  logic conv_q, conv_d;
  logic kind_q, kind_d;
  logic qok_q, qok_d;
  logic signed [62:0] qdist_q, qdist_d;
  logic qreach_q, qreach_d;

  logic ov_q, ov_d, out_load;
  logic okind_q, oreach_q, oconv_q;
  logic signed [62:0] odist_q;
  logic [10:0] opass_q;

  logic accept;

  logic es_we;
  logic [10:0] es_addr;
  logic [12:0] es_wdata, es_rdata;
  logic eg_we;
  logic [EW-1:0] eg_addr;
  logic [VW-1:0] nb_rdata;
  logic [31:0] wt_rdata;
  logic dist_we;
  logic [DAW-1:0] dist_addr;
  logic [62:0] dist_wdata, dist_rdata;
  relax_res_t alu_res;

  assign lcount_q7 = {4'd0, lcount_q};

  always_comb begin
    nv = vcount_q;
    if (vcount_q == 11'd0) nv = 11'd1;
    if (vcount_q > 11'(MAX_VERTICES)) nv = 11'(MAX_VERTICES);
    nl = lcount_q;
    if (lcount_q == 7'd0) nl = 7'd1;
    if (lcount_q7 > 11'(LANES)) nl = 7'(LANES);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= 11'd1;
      lcount_q <= 7'd1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_VCOUNT) vcount_q <= cfg_data_i;
      else if (cfg_idx_i == CFG_LCOUNT) lcount_q <= cfg_data_i[6:0];
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept = in_valid_i && !in_stall_o;

  msbf_ram #(.WIDTH(13), .DEPTH(ES_DEPTH)) u_edge_start (
    .clk_i(clk_i), .we_i(es_we), .addr_i(es_addr), .wdata_i(es_wdata), .rdata_o(es_rdata)
  );
  msbf_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_neighbour (
    .clk_i(clk_i), .we_i(eg_we), .addr_i(eg_addr), .wdata_i(vertex_i), .rdata_o(nb_rdata)
  );
  msbf_ram #(.WIDTH(32), .DEPTH(MAX_EDGES)) u_weight (
    .clk_i(clk_i), .we_i(eg_we), .addr_i(eg_addr), .wdata_i(edge_weight_i),
    .rdata_o(wt_rdata)
  );
  msbf_ram #(.WIDTH(63), .DEPTH(DIST_DEPTH)) u_distance (
    .clk_i(clk_i), .we_i(dist_we), .addr_i(dist_addr), .wdata_i(dist_wdata),
    .rdata_o(dist_rdata)
  );

  msbf_relax_alu u_alu (
    .src_i(src_q), .weight_i(w_q), .dst_i(dist_rdata), .res_o(alu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      clr_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    lo_q <= lo_d;
    hi_q <= hi_d;
    e_q <= e_d;
    nb_q <= nb_d;
    w_q <= w_d;
    l_q <= l_d;
    src_q <= src_d;
    changed_q <= changed_d;
    pass_q <= pass_d;
    conv_q <= conv_d;
    kind_q <= kind_d;
    qok_q <= qok_d;
    qdist_q <= qdist_d;
    qreach_q <= qreach_d;
    if (out_load) begin
      okind_q <= kind_q;
      odist_q <= kind_q ? qdist_q : '0;
      oreach_q <= kind_q ? qreach_q : 1'b0;
      opass_q <= kind_q ? 11'd0 : pass_q;
      oconv_q <= kind_q ? 1'b0 : conv_q;
    end
  end

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    v_d = v_q;
    lo_d = lo_q;
    hi_d = hi_q;
    e_d = e_q;
    nb_d = nb_q;
    w_d = w_q;
    l_d = l_q;
    src_d = src_q;
    changed_d = changed_q;
    pass_d = pass_q;
    conv_d = conv_q;
    kind_d = kind_q;
    qok_d = qok_q;
    qdist_d = qdist_q;
    qreach_d = qreach_q;
    out_load = 1'b0;

    es_we = 1'b0;
    es_addr = (state_q == ST_V_RD1) ? (v_q + 11'd1) : v_q;
    es_wdata = offset_value_i;
    eg_we = 1'b0;
    eg_addr = e_q[EW-1:0];
    dist_we = 1'b0;
    dist_addr = {v_q[VW-1:0], l_q[LW-1:0]};
    dist_wdata = alu_res.sum;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (action_i)
            ACT_LOAD_OFS: begin
              if (slot_i <= 13'(MAX_VERTICES)) begin
                es_we = 1'b1;
                es_addr = slot_i[10:0];
              end
            end
            ACT_LOAD_EDGE: begin
              if (slot_i < 13'(MAX_EDGES)) begin
                eg_we = 1'b1;
                eg_addr = slot_i[EW-1:0];
              end
            end
            ACT_CLEAR: begin
              clr_d = '0;
              state_d = ST_CLR;
            end
            ACT_SET_SRC: begin
              if ({1'b0, vertex_i} < nv) begin
                dist_we = 1'b1;
                dist_addr = {vertex_i, lane_i};
                dist_wdata = '0;
              end
            end
            ACT_RELAX: begin
              v_d = '0;
              pass_d = '0;
              changed_d = 1'b0;
              kind_d = 1'b0;
              state_d = ST_V_RD0;
            end
            ACT_QUERY: begin
              // issue the read now, data arrives next cycle
              dist_addr = {vertex_i, lane_i};
              qok_d = ({1'b0, vertex_i} < nv);
              kind_d = 1'b1;
              state_d = ST_Q_WAIT;
            end
            default: ;
          endcase
        end
      end
      ST_CLR: begin
        dist_we = 1'b1;
        dist_addr = clr_q;
        dist_wdata = DIST_INF;
        clr_d = clr_q + 1'b1;
        if (clr_q == {DAW{1'b1}}) state_d = ST_IDLE;
      end
      ST_V_RD0: state_d = ST_V_RD1;
      ST_V_RD1: begin
        lo_d = es_rdata;
        state_d = ST_V_CHK;
      end
      ST_V_CHK: begin
        e_d = lo_q;
        hi_d = (es_rdata > 13'(MAX_EDGES)) ? 13'(MAX_EDGES) : es_rdata;
        state_d = ST_E_RD;
      end
      ST_E_RD: begin
        if (e_q < hi_q) begin
          state_d = ST_E_CHK;
        end else if (v_q + 11'd1 < nv) begin
          v_d = v_q + 11'd1;
          state_d = ST_V_RD0;
        end else begin
          state_d = ST_PASS_END;
        end
      end
      ST_E_CHK: begin
        nb_d = nb_rdata;
        w_d = wt_rdata;
        l_d = '0;
        if ({1'b0, nb_rdata} < nv) begin
          state_d = ST_L_SRC;
        end else begin
          e_d = e_q + 13'd1;
          state_d = ST_E_RD;
        end
      end
      ST_L_SRC: state_d = ST_L_DST;
      ST_L_DST: begin
        src_d = dist_rdata;
        dist_addr = {nb_q, l_q[LW-1:0]};
        state_d = ST_L_CMP;
      end
      ST_L_CMP: begin
        dist_addr = {nb_q, l_q[LW-1:0]};
        if (alu_res.upd) begin
          dist_we = 1'b1;
          changed_d = 1'b1;
        end
        if (l_q + 7'd1 < nl) begin
          l_d = l_q + 7'd1;
          state_d = ST_L_SRC;
        end else begin
          e_d = e_q + 13'd1;
          state_d = ST_E_RD;
        end
      end
      ST_PASS_END: begin
        pass_d = pass_q + 11'd1;
        if (!changed_q) begin
          conv_d = 1'b1;
          state_d = ST_RESP;
        end else if (pass_q + 11'd1 >= nv) begin
          conv_d = 1'b0;
          state_d = ST_RESP;
        end else begin
          changed_d = 1'b0;
          v_d = '0;
          state_d = ST_V_RD0;
        end
      end
      ST_Q_WAIT: begin
        qreach_d = qok_q && ($signed(dist_rdata) < DIST_INF);
        qdist_d = (qok_q && ($signed(dist_rdata) < DIST_INF)) ? dist_rdata : '0;
        state_d = ST_RESP;
      end
      ST_RESP: begin
        // hold until the output register is free
        if (!ov_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    ov_d = (ov_q && out_stall_i) || out_load;
  end

  assign out_valid_o = ov_q;
  assign result_kind_o = okind_q;
  assign distance_o = odist_q;
  assign reachable_o = oreach_q;
  assign passes_o = opass_q;
  assign converged_o = oconv_q;

  a_edge_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_E_CHK |-> e_q < 13'(MAX_EDGES))
    else $error("edge index beyond edge store");

  a_pass_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP) && !kind_q |-> (pass_q <= nv) && (pass_q != 11'd0))
    else $error("pass count outside 1..vertex count");

  a_unreach_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !reachable_o |-> distance_o == '0)
    else $error("unreachable answer carries a distance");

  a_cap_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !result_kind_o && !converged_o |-> passes_o == nv)
    else $error("non-converged relax stopped before the cap");

endmodule

// ----- tb/sv/multi_source_bellman_ford_tb.sv -----
// Self-checking testbench for the multi-source Bellman-Ford block.
module multi_source_bellman_ford_tb;
  import msbf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;
  localparam longint INF_DIST = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam longint MIN_DIST = -INF_DIST - 1;
  localparam int IDLE_LIMIT = 500000;
  localparam int ITEM_TARGET = 1350;

  typedef struct {
    logic [2:0]         act;
    logic [12:0]        slot;
    logic [12:0]        ofs;
    logic [9:0]         vtx;
    logic signed [31:0] wgt;
    logic [5:0]         lane;
  } word_t;

  typedef struct {
    logic        kind;
    logic [62:0] path_len;
    logic        reach;
    logic [10:0] passes;
    logic        conv;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [10:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] action_i = '0;
  logic [12:0] slot_i = '0;
  logic [12:0] offset_value_i = '0;
  logic [9:0] vertex_i = '0;
  logic signed [31:0] edge_weight_i = '0;
  logic [5:0] lane_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic result_kind_o;
  logic signed [62:0] distance_o;
  logic reachable_o;
  logic [10:0] passes_o;
  logic converged_o;

  multi_source_bellman_ford u_dut (.*);

  always #2 clk_i = ~clk_i;

  // Shadow state of the graph, the lane distances and the registers.
  int unsigned        row_start [0:MAX_VERTICES];
  logic [9:0]         edge_nbr [0:MAX_EDGES-1];
  logic signed [31:0] edge_wgt [0:MAX_EDGES-1];
  longint             lane_dist [0:DIST_DEPTH-1];
  int unsigned        vcount_reg = 1;
  int unsigned        lcount_reg = 1;

  word_t   pending_words[$];
  answer_t expected_answers[$];
  int      error_count = 0;
  int      word_count = 0;

  function automatic int unsigned used_vertices();
    if (vcount_reg < 1) return 1;
    if (vcount_reg > MAX_VERTICES) return MAX_VERTICES;
    return vcount_reg;
  endfunction

  function automatic int unsigned used_lanes();
    if (lcount_reg < 1) return 1;
    if (lcount_reg > LANES) return LANES;
    return lcount_reg;
  endfunction

  function automatic void wipe_distances();
    foreach (lane_dist[i]) lane_dist[i] = INF_DIST;
  endfunction

  function automatic bit sweep_edges(int unsigned nv, int unsigned nl);
    bit changed = 0;
    int unsigned lo, hi, n;
    longint d, s;
    for (int unsigned v = 0; v < nv; v++) begin
      lo = row_start[v];
      hi = row_start[v+1];
      if (hi > MAX_EDGES) hi = MAX_EDGES;
      for (int unsigned e = lo; e < hi; e++) begin
        n = edge_nbr[e];
        if (n >= nv) continue;
        for (int unsigned l = 0; l < nl; l++) begin
          d = lane_dist[v*LANES+l];
          if (d >= INF_DIST) continue;
          s = d + longint'(edge_wgt[e]);
          if (s > INF_DIST) s = INF_DIST;
          if (s < MIN_DIST) s = MIN_DIST;
          if (s < lane_dist[n*LANES+l]) begin
            lane_dist[n*LANES+l] = s;
            changed = 1;
          end
        end
      end
    end
    return changed;
  endfunction

  // Update the shadow state and queue the answer, if any, for one word.
  function automatic void predict_answer(word_t w);
    int unsigned nv = used_vertices();
    int unsigned cnt = 0;
    bit conv = 0;
    longint d;
    answer_t a = '{default: '0};
    case (w.act)
      ACT_LOAD_OFS: if (w.slot <= MAX_VERTICES) row_start[w.slot] = w.ofs;
      ACT_LOAD_EDGE: begin
        if (w.slot < MAX_EDGES) begin
          edge_nbr[w.slot] = w.vtx;
          edge_wgt[w.slot] = w.wgt;
        end
      end
      ACT_CLEAR: wipe_distances();
      ACT_SET_SRC: if (w.vtx < nv) lane_dist[w.vtx*LANES+w.lane] = 0;
      ACT_RELAX: begin
        forever begin
          cnt++;
          if (!sweep_edges(nv, used_lanes())) begin
            conv = 1;
            break;
          end
          if (cnt >= nv) break;
        end
        a.passes = cnt[10:0];
        a.conv = conv;
        expected_answers.push_back(a);
      end
      ACT_QUERY: begin
        d = (w.vtx < nv) ? lane_dist[w.vtx*LANES+w.lane] : INF_DIST;
        a.kind = 1'b1;
        if (d < INF_DIST) begin
          a.path_len = d[62:0];
          a.reach = 1'b1;
        end
        expected_answers.push_back(a);
      end
      default: ;
    endcase
  endfunction

  function automatic void send_word(logic [2:0] act, int slot, int ofs, int vtx,
                                    logic signed [31:0] wgt, int lane);
    word_t w;
    w.act = act;
    w.slot = 13'(slot);
    w.ofs = 13'(ofs);
    w.vtx = 10'(vtx);
    w.wgt = wgt;
    w.lane = 6'(lane);
    predict_answer(w);
    pending_words.push_back(w);
    word_count++;
  endfunction

  function automatic logic signed [31:0] pick_weight();
    case ($urandom_range(0, 15))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $urandom;
      default: return $signed($urandom_range(0, 40)) - 8;
    endcase
  endfunction

  // Random graph in CSR form, then a mix of sources, relaxes, queries and noise.
  function automatic void random_phase();
    int unsigned nv = used_vertices();
    int unsigned span = $urandom_range(0, 3 * nv);
    int unsigned base = $urandom_range(0, MAX_EDGES - span);
    bit jumbled = (nv <= 6) && ($urandom_range(0, 4) == 0);
    bit cut_tail = ($urandom_range(0, 9) == 0);
    int unsigned starts[];
    int unsigned nops = $urandom_range(15, 35);
    int unsigned r;
    if (cut_tail) base = MAX_EDGES - span;
    starts = new[nv + 1];
    foreach (starts[v]) starts[v] = $urandom_range(base, base + span);
    if (!jumbled) starts.sort();
    if (cut_tail) starts[nv] = $urandom_range(MAX_EDGES, 8191);
    foreach (starts[v]) send_word(ACT_LOAD_OFS, v, starts[v], $urandom, $urandom, $urandom);
    for (int unsigned e = base; e < base + span; e++)
      send_word(ACT_LOAD_EDGE, e, $urandom,
                ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, nv),
                pick_weight(), $urandom);
    if ($urandom_range(0, 7) == 0) send_word(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
    repeat (nops) begin
      r = $urandom_range(0, 99);
      if (r < 20)
        send_word(ACT_SET_SRC, $urandom, $urandom, $urandom_range(0, nv),
                  $urandom, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, used_lanes()));
      else if (r < 30)
        send_word(ACT_RELAX, $urandom, $urandom, $urandom, $urandom, $urandom);
      else if (r < 70)
        send_word(ACT_QUERY, $urandom, $urandom,
                  ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, nv),
                  $urandom, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, used_lanes()));
      else if (r < 80)
        // keep noise off the offset entries that a relax reads
        send_word(ACT_LOAD_OFS, $urandom_range(nv + 1, 8191), $urandom, $urandom, $urandom, $urandom);
      else if (r < 90)
        send_word(ACT_LOAD_EDGE, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
        send_word($urandom_range(0, 1) ? ACT_SPARE6 : ACT_SPARE7, $urandom, $urandom,
                  $urandom, $urandom, $urandom);
    end
    send_word(ACT_QUERY, $urandom, $urandom, $urandom_range(0, nv - 1), $urandom, 0);
  endfunction

  task automatic wait_idle();
    while (pending_words.size() != 0 || expected_answers.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= 11'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_VCOUNT) vcount_reg = value & 11'h7FF;
    else lcount_reg = value & 7'h7F;
  endtask

  initial begin
    int unsigned vraw, lraw;
    foreach (row_start[i]) row_start[i] = 0;
    wipe_distances();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Defaults after reset: single vertex, single lane, nothing reachable.
    send_word(ACT_QUERY, 0, 0, 0, 0, 0);
    send_word(ACT_SPARE6, 8191, 8191, 1023, 32'sh7FFF_FFFF, 63);
    send_word(ACT_SPARE7, 0, 0, 0, 32'sh8000_0000, 0);
    send_word(ACT_LOAD_OFS, 8191, 8191, 0, 0, 0);
    send_word(ACT_LOAD_EDGE, 8191, 0, 1023, -1, 0);
    send_word(ACT_SET_SRC, 0, 0, 1023, 0, 5);
    send_word(ACT_QUERY, 0, 0, 1023, 0, 63);
    wait_idle();

    // Small graph with a reversed range, an out-of-range neighbour and extreme weights.
    write_reg(CFG_VCOUNT, 4);
    write_reg(CFG_LCOUNT, 2);
    send_word(ACT_LOAD_OFS, 0, 0, 0, 0, 0);
    send_word(ACT_LOAD_OFS, 1, 2, 0, 0, 0);
    send_word(ACT_LOAD_OFS, 2, 4, 0, 0, 0);
    send_word(ACT_LOAD_OFS, 3, 4, 0, 0, 0);
    send_word(ACT_LOAD_OFS, 4, 1, 0, 0, 0);
    send_word(ACT_LOAD_EDGE, 0, 0, 1, 32'sh7FFF_FFFF, 0);
    send_word(ACT_LOAD_EDGE, 1, 0, 1023, 5, 0);
    send_word(ACT_LOAD_EDGE, 2, 0, 2, 32'sh8000_0000, 0);
    send_word(ACT_LOAD_EDGE, 3, 0, 3, 7, 0);
    send_word(ACT_SET_SRC, 0, 0, 0, 0, 0);
    send_word(ACT_SET_SRC, 0, 0, 1, 0, 1);
    send_word(ACT_SET_SRC, 0, 0, 2, 0, 2);
    send_word(ACT_RELAX, 0, 0, 0, 0, 0);
    for (int v = 0; v < 5; v++) send_word(ACT_QUERY, 0, 0, v, 0, v % 3);
    send_word(ACT_QUERY, 0, 0, 0, 0, 63);
    wait_idle();

    // Register extremes: all vertices, all lanes, a chain at the edge store's end.
    write_reg(CFG_VCOUNT, 2047);
    write_reg(CFG_LCOUNT, 127);
    for (int v = 0; v <= MAX_VERTICES; v++)
      send_word(ACT_LOAD_OFS, v, (v < 8) ? 4088 + v : (v == 8) ? 8191 : 0, 0, 0, 0);
    for (int v = 0; v < 8; v++)
      send_word(ACT_LOAD_EDGE, 4088 + v, 0, (v == 7) ? 1023 : v + 1,
                (v == 0) ? 32'sh7FFF_FFFF : (v == 7) ? 32'sh8000_0000 : 3, 0);
    send_word(ACT_SET_SRC, 0, 0, 0, 0, 63);
    send_word(ACT_SET_SRC, 0, 0, 3, 0, 0);
    send_word(ACT_RELAX, 0, 0, 0, 0, 0);
    send_word(ACT_QUERY, 0, 0, 1023, 0, 63);
    send_word(ACT_QUERY, 0, 0, 1023, 0, 0);
    send_word(ACT_QUERY, 0, 0, 8, 0, 63);
    wait_idle();
    send_word(ACT_CLEAR, 0, 0, 0, 0, 0);
    send_word(ACT_QUERY, 0, 0, 1023, 0, 63);
    wait_idle();

    while (word_count < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: vraw = 0;
        1: vraw = 1;
        default: vraw = $urandom_range(2, 12);
      endcase
      case ($urandom_range(0, 19))
        0: lraw = 0;
        1: lraw = 64;
        2: lraw = 127;
        default: lraw = $urandom_range(1, 8);
      endcase
      write_reg(CFG_VCOUNT, vraw);
      write_reg(CFG_LCOUNT, lraw);
      random_phase();
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("multi_source_bellman_ford_tb: PASS");
    end else begin
      $display("multi_source_bellman_ford_tb: FAIL");
    end
    $finish;
  end

  // Sender: bursts of words with random gaps; hold the word while stalled.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    word_t w;
    if (rst_ni && (!in_valid_i || !in_stall_o)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() != 0) begin
        w = pending_words.pop_front();
        in_valid_i <= 1'b1;
        action_i <= w.act;
        slot_i <= w.slot;
        offset_value_i <= w.ofs;
        vertex_i <= w.vtx;
        edge_weight_i <= w.wgt;
        lane_i <= w.lane;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern switches between free-running, patchy and mostly held.
  int stall_mode = 0;
  int stall_span = 0;
  always @(posedge clk_i) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_span <= $urandom_range(20, 300);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= $urandom_range(0, 1);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Check each accepted answer against the oldest expectation.
  always @(posedge clk_i) begin
    answer_t a;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_answers.size() == 0) begin
        $error("unexpected answer: kind %0d", result_kind_o);
        error_count++;
      end else begin
        a = expected_answers.pop_front();
        if (result_kind_o !== a.kind) begin
          $error("result_kind: expected %0d, got %0d", a.kind, result_kind_o);
          error_count++;
        end
        if (distance_o !== a.path_len) begin
          $error("distance: expected %0d, got %0d", $signed(a.path_len), distance_o);
          error_count++;
        end
        if (reachable_o !== a.reach) begin
          $error("reachable: expected %0d, got %0d", a.reach, reachable_o);
          error_count++;
        end
        if (passes_o !== a.passes) begin
          $error("passes: expected %0d, got %0d", a.passes, passes_o);
          error_count++;
        end
        if (converged_o !== a.conv) begin
          $error("converged: expected %0d, got %0d", a.conv, converged_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog: count cycles in which no word moves on either side.
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("multi_source_bellman_ford_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ----- files.f -----
rtl/core/msbf_pkg.sv
rtl/core/msbf_ram.sv
rtl/core/msbf_relax_alu.sv
rtl/core/multi_source_bellman_ford.sv
tb/sv/multi_source_bellman_ford_tb.sv
